// ===== src/double_click_long_press_detector_unit_defines.svh =====
// Assertion macros shared by the gesture detector RTL.
`ifndef DOUBLE_CLICK_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH
`define DOUBLE_CLICK_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define DCLP_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dclp assertion failed");

`define DCLP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dclp assertion failed");

`else

`define DCLP_ASSERT_SAME(name, ante, cons)

`define DCLP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== src/dclp_pkg.sv =====
// Types, widths and register codes of the gesture detector.
package dclp_pkg;

	localparam int ClockW     = 40;
	localparam int ElapsedW   = 20;
	localparam int WindowW    = 24;
	localparam int RadiusW    = 12;
	localparam int RadiusSqW  = 2 * RadiusW;
	localparam int PosW       = 16;
	localparam int DiffW      = PosW + 1;
	localparam int SquareW    = 2 * DiffW;
	localparam int DistW      = 34;
	localparam int AddrW      = 4;
	localparam int DataW      = 32;

	localparam logic [WindowW-1:0]   DoubleWindowRst = 24'd300000;
	localparam logic [WindowW-1:0]   LongPressRst    = 24'd500000;
	localparam logic [RadiusW-1:0]   MoveRadiusRst   = 12'd96;
	localparam logic [RadiusSqW-1:0] RadiusSqRst     = 24'd9216;

	typedef enum logic [1:0] {
		RegDoubleWindow = 2'd0,
		RegLongPress    = 2'd1,
		RegMoveRadius   = 2'd2
	} dclp_reg_t;

	typedef struct packed {
		logic [ElapsedW-1:0]    elapsed_us;
		logic                   press_edge;
		logic                   release_edge;
		logic                   button_held;
		logic signed [PosW-1:0] pointer_x;
		logic signed [PosW-1:0] pointer_y;
	} dclp_frame_t;

	typedef struct packed {
		logic double_click;
		logic long_press;
	} dclp_result_t;

endpackage

// ===== src/dclp_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transfer.
interface dclp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/double_click_long_press_detector_unit.sv =====
// Top level of the double-click and long-press gesture detector.
// A frame accepted into the input register yields its result in the result register.
// One frame per cycle while results are taken; the input register, the single-pass gesture
// logic and the result register form a two-stage path that stalls while a held result is not taken.
// Reset clears the gesture clock and all gesture state and loads the register defaults.
`include "double_click_long_press_detector_unit_defines.svh"

module double_click_long_press_detector_unit
	import dclp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	dclp_stream_if.sink         frame_in,
	dclp_stream_if.source       result_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [AddrW-1:0]    paddr,
	input  logic [DataW-1:0]    pwdata,
	output logic [DataW-1:0]    prdata,
	output logic                pready
);

	logic [WindowW-1:0]   window_q;
	logic [WindowW-1:0]   long_q;
	logic [RadiusW-1:0]   radius_q;
	logic [RadiusSqW-1:0] radius_sq_q;
	dclp_reg_t            reg_sel;
	logic                 cfg_write;

	dclp_frame_t          frame_s1;
	logic                 valid_s1;
	logic                 advance;

	dclp_result_t         result_q;
	logic                 out_valid_q;

	logic [ClockW-1:0]    clock_q;
	logic [ClockW-1:0]    first_time_q;
	logic [ClockW-1:0]    start_time_q;
	logic [PosW-1:0]      origin_x_q;
	logic [PosW-1:0]      origin_y_q;
	logic                 pending_q;
	logic                 armed_q;
	logic                 done_q;

	logic [ClockW-1:0]    clock_next;
	logic [ClockW-1:0]    window_gap;
	logic [ClockW-1:0]    hold_gap;
	logic signed [DiffW-1:0]   dx;
	logic signed [DiffW-1:0]   dy;
	logic signed [SquareW-1:0] sq_x;
	logic signed [SquareW-1:0] sq_y;
	logic [DistW-1:0]     dist_sq;
	logic                 near_origin;
	logic                 click_fresh;

	logic [ClockW-1:0]    n_first_time;
	logic [ClockW-1:0]    n_start_time;
	logic [PosW-1:0]      n_origin_x;
	logic [PosW-1:0]      n_origin_y;
	logic                 n_pending;
	logic                 n_armed;
	logic                 n_done;
	dclp_result_t         n_result;

	assign pready    = 1'b1;
	assign reg_sel   = dclp_reg_t'(paddr[AddrW-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= DoubleWindowRst;
			long_q      <= LongPressRst;
			radius_q    <= MoveRadiusRst;
			radius_sq_q <= RadiusSqRst;
		end else begin
			if (cfg_write) begin
				case (reg_sel)
					RegDoubleWindow: window_q <= pwdata[WindowW-1:0];
					RegLongPress:    long_q   <= pwdata[WindowW-1:0];
					RegMoveRadius: begin
						radius_q    <= pwdata[RadiusW-1:0];
						radius_sq_q <= RadiusSqW'(pwdata[RadiusW-1:0])
							* RadiusSqW'(pwdata[RadiusW-1:0]);
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (reg_sel)
			RegDoubleWindow: prdata = {{(DataW-WindowW){1'b0}}, window_q};
			RegLongPress:    prdata = {{(DataW-WindowW){1'b0}}, long_q};
			RegMoveRadius:   prdata = {{(DataW-RadiusW){1'b0}}, radius_q};
			default:         prdata = '0;
		endcase
	end

	assign advance        = valid_s1 && (!out_valid_q || result_out.ready);
	assign frame_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			frame_s1 <= frame_in.data;
		end
	end

	assign clock_next = clock_q + {{(ClockW-ElapsedW){1'b0}}, frame_s1.elapsed_us};
	assign window_gap = clock_next - first_time_q;
	assign hold_gap   = clock_next - start_time_q;

	assign dx   = {frame_s1.pointer_x[PosW-1], frame_s1.pointer_x}
		- {origin_x_q[PosW-1], origin_x_q};
	assign dy   = {frame_s1.pointer_y[PosW-1], frame_s1.pointer_y}
		- {origin_y_q[PosW-1], origin_y_q};
	assign sq_x = dx * dx;
	assign sq_y = dy * dy;
	assign dist_sq = DistW'($unsigned(sq_x)) + DistW'($unsigned(sq_y));

	assign near_origin = dist_sq <= {{(DistW-RadiusSqW){1'b0}}, radius_sq_q};
	assign click_fresh = pending_q && (window_gap <= {{(ClockW-WindowW){1'b0}}, window_q});

	// A press in the same frame as held skips the hold check, which sits behind the press branch,
	// so it can neither cancel nor fire; only older holds are tested.
	always_comb begin
		n_first_time = first_time_q;
		n_start_time = start_time_q;
		n_origin_x   = origin_x_q;
		n_origin_y   = origin_y_q;
		n_pending    = pending_q;
		n_armed      = armed_q;
		n_done       = done_q;
		n_result     = '0;

		if (frame_s1.press_edge) begin
			if (click_fresh && near_origin) begin
				n_result.double_click = 1'b1;
				n_pending             = 1'b0;
			end else begin
				n_first_time = clock_next;
				n_pending    = 1'b1;
			end
			n_origin_x   = frame_s1.pointer_x;
			n_origin_y   = frame_s1.pointer_y;
			n_start_time = clock_next;
			n_armed      = 1'b1;
			n_done       = 1'b0;
		end else if (frame_s1.button_held && armed_q && !done_q && (long_q != '0)) begin
			if (!near_origin) begin
				n_armed = 1'b0;
			end else if (hold_gap >= {{(ClockW-WindowW){1'b0}}, long_q}) begin
				n_result.long_press = 1'b1;
				n_done              = 1'b1;
			end
		end

		if (frame_s1.release_edge) begin
			n_armed = 1'b0;
			n_done  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q      <= '0;
			first_time_q <= '0;
			start_time_q <= '0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			pending_q    <= 1'b0;
			armed_q      <= 1'b0;
			done_q       <= 1'b0;
		end else if (advance) begin
			clock_q      <= clock_next;
			first_time_q <= n_first_time;
			start_time_q <= n_start_time;
			origin_x_q   <= n_origin_x;
			origin_y_q   <= n_origin_y;
			pending_q    <= n_pending;
			armed_q      <= n_armed;
			done_q       <= n_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= n_result;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.data  = result_q;

	`DCLP_ASSERT_SAME(a_no_both, out_valid_q, !(result_q.double_click && result_q.long_press))
	`DCLP_ASSERT_NEXT(a_dbl_consumes, advance && n_result.double_click, !pending_q)
	`DCLP_ASSERT_NEXT(a_long_once, advance && n_result.long_press && !frame_s1.release_edge, done_q)
	`DCLP_ASSERT_SAME(a_ready_when_empty, !out_valid_q, frame_in.ready)

endmodule
